>>> design/wall_follow_pd_motor_drive_assert.svh
// Assertion macros for the wall follower checks
`ifndef WALL_FOLLOW_PD_MOTOR_DRIVE_ASSERT_SVH
`define WALL_FOLLOW_PD_MOTOR_DRIVE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define WFPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wall follower check failed");

// next-cycle implication
`define WFPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wall follower check failed");

`endif

>>> design/wfpd_pkg.sv
`default_nettype none

package wfpd_pkg;

  localparam int unsigned DistW   = 10;
  localparam int unsigned GainW   = 16;
  localparam int unsigned SpeedW  = 7;
  localparam int unsigned DutyW   = 8;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgW    = 16;

  localparam logic [DistW-1:0] SideThreshold = 10'd80;
  localparam logic [7:0]       FullDuty      = 8'd255;
  localparam logic [6:0]       Percent       = 7'd100;

  // floor(2^22 / 100): quotient estimate is exact or one short
  localparam int unsigned RecipShift = 22;
  localparam logic [15:0] RecipK     = 16'd41943;

  localparam logic [CfgIdxW-1:0] REG_PROP_GAIN   = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_DERIV_GAIN  = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_TARGET_DIST = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_SPEED_PCT   = 8'd3;

endpackage

`default_nettype wire

>>> design/wfpd_if.sv
`default_nettype none

interface wfpd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [wfpd_pkg::CfgIdxW-1:0] index;
  logic [wfpd_pkg::CfgW-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface wfpd_in_if;
  logic                       valid;
  logic                       ready;
  logic [wfpd_pkg::DistW-1:0] right_front_dist;
  logic [wfpd_pkg::DistW-1:0] left_front_dist;
  modport source (output valid, output right_front_dist, output left_front_dist,
                  input ready);
  modport sink (input valid, input right_front_dist, input left_front_dist,
                output ready);
endinterface

interface wfpd_out_if;
  logic                              valid;
  logic                              ready;
  logic [wfpd_pkg::DutyW-1:0]        duty_a;
  logic [wfpd_pkg::DutyW-1:0]        duty_b;
  logic signed [wfpd_pkg::GainW-1:0] steer_term;
  logic                              left_side_used;
  modport source (output valid, output duty_a, output duty_b, output steer_term,
                  output left_side_used, input ready);
  modport sink (input valid, input duty_a, input duty_b, input steer_term,
                input left_side_used, output ready);
endinterface

`default_nettype wire

>>> design/wall_follow_pd_motor_drive.sv
// Wall-following PD steering with one shared 23x17 signed multiplier.
// A new request is accepted only once the last result is loaded; each request runs
// accept, eight multiplier passes (two PD terms, two speed products, two reciprocal
// divides by 100 of two passes each), pd saturation and output load; a stalled result
// holds the block in its last step.
// Reset (rst, synchronous): gains to 1.0 and 0, target and speed to 0,
// both stored errors to 0, no result pending.
`default_nettype none

module wall_follow_pd_motor_drive (
  input logic         clk,
  input logic         rst,
  wfpd_cfg_if.sink    cfg,
  wfpd_in_if.sink     sensor,
  wfpd_out_if.source  drive
);

  typedef enum logic [3:0] {
    IDLE, MUL_P, MUL_D, PD_SAT, MUL_S, DIV_Q, DIV_R, MUL_B, DONE
  } state_t;

  state_t state;

  logic signed [15:0] prop_gain;
  logic signed [15:0] deriv_gain;
  logic [9:0]         target_distance;
  logic [6:0]         speed_percent;

  logic signed [10:0] last_left_error;
  logic signed [10:0] last_right_error;
  logic signed [10:0] err;
  logic signed [11:0] diff;
  logic               left_used;
  logic signed [29:0] acc;
  logic signed [15:0] pd;
  logic               neg_adj;
  logic               pass_base;
  logic [21:0]        num;
  logic [15:0]        quot;
  logic [15:0]        adj_mag;
  logic [8:0]         base;

  logic               out_valid;
  logic [7:0]         duty_a;
  logic [7:0]         duty_b;
  logic signed [15:0] steer_term;
  logic               left_side_used;

  // config
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain       <= 16'sd256;
      deriv_gain      <= 16'sd0;
      target_distance <= 10'd0;
      speed_percent   <= 7'd0;
    end else if (cfg.valid) begin
      case (cfg.index)
        wfpd_pkg::REG_PROP_GAIN:   prop_gain       <= cfg.data;
        wfpd_pkg::REG_DERIV_GAIN:  deriv_gain      <= cfg.data;
        wfpd_pkg::REG_TARGET_DIST: target_distance <= cfg.data[9:0];
        wfpd_pkg::REG_SPEED_PCT:   speed_percent   <= cfg.data[6:0];
        default: ;
      endcase
    end
  end

  // request decode
  logic               use_left;
  logic [9:0]         reading;
  logic signed [10:0] prev_err;
  logic signed [10:0] err_new;
  logic signed [11:0] diff_new;

  always_comb begin
    use_left = sensor.right_front_dist > wfpd_pkg::SideThreshold;
    reading  = use_left ? sensor.left_front_dist : sensor.right_front_dist;
    prev_err = use_left ? last_left_error : last_right_error;
    err_new  = $signed({1'b0, target_distance}) - $signed({1'b0, reading});
    diff_new = $signed({err_new[10], err_new}) - $signed({prev_err[10], prev_err});
  end

  // shared multiplier
  logic signed [22:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [39:0] prod;
  logic [15:0]        pd_mag;

  assign pd_mag = pd[15] ? 16'(~pd + 16'sd1) : 16'(pd);

  always_comb begin
    case (state)
      MUL_P: begin
        mul_a = {{12{err[10]}}, err};
        mul_b = {prop_gain[15], prop_gain};
      end
      MUL_D: begin
        mul_a = {{11{diff[11]}}, diff};
        mul_b = {deriv_gain[15], deriv_gain};
      end
      MUL_S: begin
        mul_a = {7'd0, pd_mag};
        mul_b = {10'd0, speed_percent};
      end
      DIV_Q: begin
        mul_a = {1'b0, num};
        mul_b = {1'b0, wfpd_pkg::RecipK};
      end
      DIV_R: begin
        mul_a = {7'd0, quot};
        mul_b = {10'd0, wfpd_pkg::Percent};
      end
      MUL_B: begin
        mul_a = {16'd0, speed_percent};
        mul_b = {9'd0, wfpd_pkg::FullDuty};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // pd: truncate toward zero, then saturate
  logic signed [29:0] acc_bias;
  logic signed [21:0] acc_div;
  logic signed [15:0] pd_sat;

  always_comb begin
    acc_bias = acc + (acc[29] ? 30'sd255 : 30'sd0);
    acc_div  = acc_bias[29:8];
    if (acc_div > 22'sd32767)
      pd_sat = 16'sh7fff;
    else if (acc_div < -22'sd32768)
      pd_sat = 16'sh8000;
    else
      pd_sat = acc_div[15:0];
  end

  // divide-by-100 correction
  logic [22:0] rem;
  logic [15:0] quot_fix;

  assign rem      = {1'b0, num} - prod[22:0];
  assign quot_fix = quot + ((rem >= 23'd100) ? 16'd1 : 16'd0);

  // duties
  logic signed [17:0] adj;
  logic signed [17:0] sum_a;
  logic signed [17:0] sum_b;
  logic [7:0]         sat_a;
  logic [7:0]         sat_b;

  always_comb begin
    adj   = neg_adj ? -$signed({2'b00, adj_mag}) : $signed({2'b00, adj_mag});
    sum_a = $signed({9'd0, base}) + adj;
    sum_b = $signed({9'd0, base}) - adj;
    if (sum_a < 18'sd0)
      sat_a = 8'd0;
    else if (sum_a > 18'sd255)
      sat_a = wfpd_pkg::FullDuty;
    else
      sat_a = sum_a[7:0];
    if (sum_b < 18'sd0)
      sat_b = 8'd0;
    else if (sum_b > 18'sd255)
      sat_b = wfpd_pkg::FullDuty;
    else
      sat_b = sum_b[7:0];
  end

  assign sensor.ready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= IDLE;
      out_valid        <= 1'b0;
      last_left_error  <= 11'sd0;
      last_right_error <= 11'sd0;
    end else begin
      if (out_valid && drive.ready && state != DONE)
        out_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (sensor.valid) begin
            err       <= err_new;
            diff      <= diff_new;
            left_used <= use_left;
            if (use_left)
              last_left_error <= err_new;
            else
              last_right_error <= err_new;
            state <= MUL_P;
          end
        end
        MUL_P: begin
          acc   <= prod[29:0];
          state <= MUL_D;
        end
        MUL_D: begin
          acc   <= acc + prod[29:0];
          state <= PD_SAT;
        end
        PD_SAT: begin
          pd    <= pd_sat;
          state <= MUL_S;
        end
        MUL_S: begin
          num       <= prod[21:0];
          neg_adj   <= pd[15] ^ left_used;
          pass_base <= 1'b0;
          state     <= DIV_Q;
        end
        DIV_Q: begin
          quot  <= prod[wfpd_pkg::RecipShift +: 16];
          state <= DIV_R;
        end
        DIV_R: begin
          if (pass_base) begin
            base  <= quot_fix[8:0];
            state <= DONE;
          end else begin
            adj_mag <= quot_fix;
            state   <= MUL_B;
          end
        end
        MUL_B: begin
          num       <= prod[21:0];
          pass_base <= 1'b1;
          state     <= DIV_Q;
        end
        DONE: begin
          if (!out_valid || drive.ready) begin
            duty_a         <= sat_a;
            duty_b         <= sat_b;
            steer_term     <= pd;
            left_side_used <= left_used;
            out_valid      <= 1'b1;
            state          <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign drive.valid          = out_valid;
  assign drive.duty_a         = duty_a;
  assign drive.duty_b         = duty_b;
  assign drive.steer_term     = steer_term;
  assign drive.left_side_used = left_side_used;

endmodule

`default_nettype wire

>>> design/wfpd_checker.sv
`default_nettype none

`include "wall_follow_pd_motor_drive_assert.svh"

module wfpd_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_ready,
  input logic        sensor_valid,
  input logic        sensor_ready,
  input logic        drive_valid,
  input logic        drive_ready,
  input logic [7:0]  duty_a,
  input logic [7:0]  duty_b,
  input logic [15:0] steer_term,
  input logic        left_side_used
);

  // stalled result holds
  `WFPD_ASSERT_NEXT(a_drive_hold, drive_valid && !drive_ready, drive_valid && $stable(duty_a) && $stable(duty_b) && $stable(steer_term) && $stable(left_side_used))

  // one request in flight at a time
  `WFPD_ASSERT_NEXT(a_busy_after_req, sensor_valid && sensor_ready, !sensor_ready)

  // no result in the cycle after a fresh request unless one was already held
  `WFPD_ASSERT_NEXT(a_no_early_result, sensor_valid && sensor_ready && !drive_valid, !drive_valid)

  // config writes never stall
  `WFPD_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready)

endmodule

bind wall_follow_pd_motor_drive wfpd_checker u_wfpd_checker (
  .clk            (clk),
  .rst            (rst),
  .cfg_ready      (cfg.ready),
  .sensor_valid   (sensor.valid),
  .sensor_ready   (sensor.ready),
  .drive_valid    (drive.valid),
  .drive_ready    (drive.ready),
  .duty_a         (drive.duty_a),
  .duty_b         (drive.duty_b),
  .steer_term     (drive.steer_term),
  .left_side_used (drive.left_side_used)
);

`default_nettype wire
